### src/spt_pkg.sv
// Shared types and constants for the serial port transmit/receive core.
// Used by spt_cfg, spt_engine and serial_port_tx_rx_core; no dependencies.
`default_nettype none

package spt_pkg;

  // Operation codes carried by an input transfer
  typedef enum logic [2:0] {
    OP_WRITE_TX  = 3'd0,
    OP_TICK      = 3'd1,
    OP_EXT_EDGE  = 3'd2,
    OP_RECEIVE   = 3'd3,
    OP_ABORT     = 3'd4,
    OP_SET_NINTH = 3'd5,
    OP_READ_BUF  = 3'd6,
    OP_CLR_STAT  = 3'd7
  } op_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_MODE     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PARITY_ENABLE  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RECEIVE_ENABLE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_KB_VARIANT     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BAUD_SETTING   = 3'd4;

  // Frame modes
  localparam logic [1:0] MODE_SHIFT  = 2'd0;
  localparam logic [1:0] MODE_ASYNC8 = 2'd1;
  localparam logic [1:0] MODE_NINE2  = 2'd2;
  localparam logic [1:0] MODE_NINE3  = 2'd3;

  // Status bit positions
  localparam int unsigned ST_RB8     = 7;
  localparam int unsigned ST_RI      = 6;
  localparam int unsigned ST_TI      = 5;
  localparam int unsigned ST_TX_EMPT = 3;
  localparam int unsigned ST_OVERRUN = 2;

  // Stop positions per frame mode
  localparam logic [3:0] STOP_SHIFT = 4'd8;
  localparam logic [3:0] STOP_ASYNC = 4'd9;
  localparam logic [3:0] STOP_NINE  = 4'd10;

  // Counter widths
  localparam int unsigned PeriodW = 20;
  localparam int unsigned EdgeW   = 19;

  typedef struct packed {
    op_e        op;
    logic [8:0] data;
  } in_item_t;

  typedef struct packed {
    logic       tx_line;
    logic [7:0] status;
    logic [7:0] rx_data;
    logic [7:0] sent_byte;
    logic       sent_valid;
    logic       irq_serial;
    logic       irq_transmit;
    logic       irq_receive;
    logic       tx_busy;
  } out_item_t;

  // Configuration as seen by the engine, with the derived internal bit period
  typedef struct packed {
    logic [1:0]         frame_mode;
    logic               parity_enable;
    logic               receive_enable;
    logic               kb_variant;
    logic [15:0]        baud_setting;
    logic [PeriodW-1:0] period;
  } cfg_t;

endpackage

`default_nettype wire

### src/serial_port_tx_rx_core.sv
// Top level of the serial port core: input register, engine, result register.
// Depends on spt_pkg, spt_cfg and spt_engine.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------
//   in      | input     | in_valid_i / in_stall_o | in_item_i  (op, data)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (result)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// An item passes from acceptance into the input register, then through the
// engine into the result register. One item per cycle is sustained while the
// output is not stalled; the engine's state update sets that rate.
// Reset leaves the transmitter idle with the line high and all status clear.
// A stalled result holds; one more item may wait in the input register.
`default_nettype none

module serial_port_tx_rx_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire spt_pkg::in_item_t           in_item_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output spt_pkg::out_item_t               out_item_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [spt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [15:0]                 cfg_data_i
);

  spt_pkg::cfg_t      cfg;
  spt_pkg::in_item_t  in_q;
  logic               in_valid_q;
  spt_pkg::out_item_t out_q, result;
  logic               out_valid_q;
  logic               out_free, fire;

  spt_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  assign out_free   = !(out_valid_q && out_stall_i);
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  spt_engine u_engine (
    .clk_i,
    .rst_ni,
    .fire_i   (fire),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Capture an input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
  end

  // Hold the result until the output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

### src/spt_cfg.sv
// Configuration registers and internal baud period derivation.
// Depends on spt_pkg.
`default_nettype none

module spt_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [spt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [15:0]                 cfg_data_i,
  output spt_pkg::cfg_t                    cfg_o
);

  // ceil(2^23 / 3): exact divide by three for dividends below 2^23
  localparam logic [21:0] Div3Recip = 22'd2796203;
  localparam int unsigned Div3Shift = 23;

  spt_pkg::cfg_t cfg_q, cfg_d, cfg_w;
  logic [15:0]   divisor;
  logic [21:0]   div_in;
  logic [43:0]   div_prod;
  logic [spt_pkg::PeriodW-1:0] period_d;

  assign cfg_ready_o = 1'b1;

  // Decode the register write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        spt_pkg::CFG_FRAME_MODE:     cfg_d.frame_mode     = cfg_data_i[1:0];
        spt_pkg::CFG_PARITY_ENABLE:  cfg_d.parity_enable  = cfg_data_i[0];
        spt_pkg::CFG_RECEIVE_ENABLE: cfg_d.receive_enable = cfg_data_i[0];
        spt_pkg::CFG_KB_VARIANT:     cfg_d.kb_variant     = cfg_data_i[0];
        spt_pkg::CFG_BAUD_SETTING:   cfg_d.baud_setting   = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Derive the internal bit period from the new settings
  assign divisor  = {1'b0, cfg_d.baud_setting[14:0]} + 16'd1;
  assign div_in   = ((cfg_d.frame_mode != spt_pkg::MODE_SHIFT) ?
                     {divisor, 6'b0} : {4'b0, divisor, 2'b0}) + 22'd2;
  assign div_prod = 44'(div_in) * 44'(Div3Recip);

  always_comb begin
    if (!cfg_d.baud_setting[15]) begin
      period_d = '0;
    end else if (cfg_d.kb_variant) begin
      period_d = (cfg_d.frame_mode != spt_pkg::MODE_SHIFT) ?
                 {divisor, 4'b0} : {3'b0, divisor, 1'b0};
    end else begin
      period_d = div_prod[Div3Shift +: spt_pkg::PeriodW];
    end
  end

  // Merge the period into the settings word
  always_comb begin
    cfg_w        = cfg_d;
    cfg_w.period = period_d;
  end

  // Hold the settings and the period
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_w;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### src/spt_engine.sv
// Transmit frame sequencer, receive status path and status register.
// Applies one item per enabled cycle; depends on spt_pkg.
`default_nettype none

module spt_engine (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  fire_i,
  input  wire spt_pkg::in_item_t     item_i,
  input  wire spt_pkg::cfg_t         cfg_i,
  output spt_pkg::out_item_t         result_o
);

  logic [7:0]  tx_shift_q, tx_shift_d;
  logic        tx_active_q, tx_active_d;
  logic [3:0]  bit_index_q, bit_index_d;
  logic [3:0]  stop_index_q, stop_index_d;
  logic [7:0]  queued_byte_q, queued_byte_d;
  logic        queued_flag_q, queued_flag_d;
  logic        line_q, line_d;
  logic        ninth_q, ninth_d;
  logic [7:0]  status_q, status_d;
  logic [7:0]  rx_byte_q, rx_byte_d;
  logic        rx_full_q, rx_full_d;
  logic [spt_pkg::EdgeW-1:0]   edge_q, edge_d;
  logic [spt_pkg::PeriodW-1:0] baud_q, baud_d;

  logic        adv, load;
  logic [7:0]  load_byte;
  logic [3:0]  bit_next;
  logic [2:0]  data_pos;
  logic        parity;
  logic [15:0] divisor;
  logic [spt_pkg::EdgeW-1:0]   edge_thr, edge_inc;
  logic [spt_pkg::PeriodW-1:0] baud_inc;
  logic [1:0]  mode;
  spt_pkg::out_item_t res;

  assign mode     = cfg_i.frame_mode;
  assign divisor  = {1'b0, cfg_i.baud_setting[14:0]} + 16'd1;
  assign edge_thr = (mode != spt_pkg::MODE_SHIFT) ? {divisor, 3'b0} : {3'b0, divisor};
  assign edge_inc = edge_q + spt_pkg::EdgeW'(1);
  assign baud_inc = baud_q + spt_pkg::PeriodW'(1);
  assign bit_next = bit_index_q + 4'd1;
  assign data_pos = 3'(bit_next - 4'd1);
  assign parity   = ^(tx_shift_q & ((mode == spt_pkg::MODE_ASYNC8) ? 8'h7F : 8'hFF));

  always_comb begin
    tx_shift_d    = tx_shift_q;
    tx_active_d   = tx_active_q;
    bit_index_d   = bit_index_q;
    stop_index_d  = stop_index_q;
    queued_byte_d = queued_byte_q;
    queued_flag_d = queued_flag_q;
    line_d        = line_q;
    ninth_d       = ninth_q;
    status_d      = status_q;
    rx_byte_d     = rx_byte_q;
    rx_full_d     = rx_full_q;
    edge_d        = edge_q;
    baud_d        = baud_q;
    adv           = 1'b0;
    load          = 1'b0;
    load_byte     = item_i.data[7:0];
    res           = '0;

    // Decode the operation
    unique case (item_i.op)
      spt_pkg::OP_WRITE_TX: begin
        status_d[spt_pkg::ST_TX_EMPT] = 1'b0;
        if (cfg_i.kb_variant && tx_active_q) begin
          queued_byte_d = item_i.data[7:0];
          queued_flag_d = 1'b1;
        end else begin
          load   = 1'b1;
          edge_d = '0;
          baud_d = '0;
        end
      end
      spt_pkg::OP_TICK: begin
        if (tx_active_q && (cfg_i.period != '0)) begin
          if (baud_inc >= cfg_i.period) begin
            baud_d = '0;
            adv    = 1'b1;
          end else begin
            baud_d = baud_inc;
          end
        end
      end
      spt_pkg::OP_EXT_EDGE: begin
        if (tx_active_q && !cfg_i.baud_setting[15]) begin
          if (edge_inc >= edge_thr) begin
            edge_d = '0;
            adv    = 1'b1;
          end else begin
            edge_d = edge_inc;
          end
        end
      end
      spt_pkg::OP_RECEIVE: begin
        if (!(cfg_i.kb_variant && !cfg_i.receive_enable)) begin
          if (rx_full_q) status_d[spt_pkg::ST_OVERRUN] = 1'b1;
          rx_byte_d = item_i.data[7:0];
          rx_full_d = 1'b1;
          if (mode[1] && !(mode == spt_pkg::MODE_NINE3 && cfg_i.parity_enable)) begin
            status_d[spt_pkg::ST_RB8] = item_i.data[8];
          end
          if (!(mode == spt_pkg::MODE_NINE2 && !item_i.data[8])) begin
            status_d[spt_pkg::ST_RI] = 1'b1;
            res.irq_serial  = 1'b1;
            res.irq_receive = cfg_i.kb_variant;
          end
        end
      end
      spt_pkg::OP_ABORT: begin
        tx_active_d   = 1'b0;
        queued_flag_d = 1'b0;
        baud_d        = '0;
        status_d[spt_pkg::ST_TX_EMPT] = 1'b1;
        line_d        = 1'b1;
      end
      spt_pkg::OP_SET_NINTH: ninth_d   = item_i.data[0];
      spt_pkg::OP_READ_BUF:  rx_full_d = 1'b0;
      spt_pkg::OP_CLR_STAT:  status_d  = status_q & ~item_i.data[7:0];
      default: ;
    endcase

    // Advance the frame by one bit time
    if (adv) begin
      bit_index_d = bit_next;
      if (bit_next < stop_index_q) begin
        if (mode == spt_pkg::MODE_SHIFT) begin
          line_d = (bit_next < 4'd8) ? tx_shift_q[bit_next[2:0]] : 1'b0;
        end else if (bit_next <= 4'd8 &&
                     !(mode == spt_pkg::MODE_ASYNC8 && cfg_i.parity_enable &&
                       bit_next == 4'd8)) begin
          line_d = tx_shift_q[data_pos];
        end else begin
          line_d = (cfg_i.parity_enable && mode != spt_pkg::MODE_NINE2) ? parity : ninth_q;
        end
      end else if (bit_next == stop_index_q) begin
        line_d  = 1'b1;
        ninth_d = 1'b0;
        status_d[spt_pkg::ST_TI] = 1'b1;
        res.irq_serial   = 1'b1;
        res.irq_transmit = cfg_i.kb_variant;
        res.sent_byte    = tx_shift_q;
        res.sent_valid   = 1'b1;
      end else if (queued_flag_q) begin
        queued_flag_d = 1'b0;
        load          = 1'b1;
        load_byte     = queued_byte_q;
      end else begin
        tx_active_d = 1'b0;
        status_d[spt_pkg::ST_TX_EMPT] = 1'b1;
      end
    end

    // Start a new frame
    if (load) begin
      tx_shift_d   = load_byte;
      tx_active_d  = 1'b1;
      bit_index_d  = '0;
      stop_index_d = mode[1] ? spt_pkg::STOP_NINE :
                     ((mode != spt_pkg::MODE_SHIFT) ? spt_pkg::STOP_ASYNC :
                                                      spt_pkg::STOP_SHIFT);
      line_d       = (mode != spt_pkg::MODE_SHIFT) ? 1'b0 : load_byte[0];
    end

    res.tx_line = line_d;
    res.status  = status_d;
    res.rx_data = rx_byte_d;
    res.tx_busy = tx_active_d;
  end

  assign result_o = res;

  // Commit the state when the item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_shift_q    <= '0;
      tx_active_q   <= 1'b0;
      bit_index_q   <= '0;
      stop_index_q  <= spt_pkg::STOP_SHIFT;
      queued_byte_q <= '0;
      queued_flag_q <= 1'b0;
      line_q        <= 1'b1;
      ninth_q       <= 1'b0;
      status_q      <= '0;
      rx_byte_q     <= '0;
      rx_full_q     <= 1'b0;
      edge_q        <= '0;
      baud_q        <= '0;
    end else if (fire_i) begin
      tx_shift_q    <= tx_shift_d;
      tx_active_q   <= tx_active_d;
      bit_index_q   <= bit_index_d;
      stop_index_q  <= stop_index_d;
      queued_byte_q <= queued_byte_d;
      queued_flag_q <= queued_flag_d;
      line_q        <= line_d;
      ninth_q       <= ninth_d;
      status_q      <= status_d;
      rx_byte_q     <= rx_byte_d;
      rx_full_q     <= rx_full_d;
      edge_q        <= edge_d;
      baud_q        <= baud_d;
    end
  end

  // Frame position never runs past the slot after the stop bit
  a_bit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_active_q |-> (5'(bit_index_q) <= 5'(stop_index_q) + 5'd1))
    else $error("bit index beyond stop slot");

  a_stop_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_index_q == spt_pkg::STOP_SHIFT || stop_index_q == spt_pkg::STOP_ASYNC ||
    stop_index_q == spt_pkg::STOP_NINE)
    else $error("illegal stop position");

  // Abort leaves the line idle and the transmitter stopped
  a_abort_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.op == spt_pkg::OP_ABORT) |=>
      (!tx_active_q && line_q && !queued_flag_q))
    else $error("abort did not stop transmitter");

  // A completed frame always raises TI
  a_sent_sets_ti: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res.sent_valid) |=> status_q[spt_pkg::ST_TI])
    else $error("sent frame without TI");

endmodule

`default_nettype wire
